// ===== rtl/gthm_pkg.sv =====
// shared types, constants and threshold tables for the halftone magnifier
`default_nettype none

package gthm_pkg;

	// line buffer geometry
	localparam int LINE_PIXELS = 128;
	localparam int GROUP       = 8;
	localparam int WORDS       = LINE_PIXELS / GROUP;
	localparam int WADDR_W     = $clog2(WORDS);
	localparam int LINE_KEEP   = (LINE_PIXELS / 32) * 32;

	// field and counter widths
	localparam int CNT_W  = 12;
	localparam int GRAY_W = 8;
	localparam int BITS_W = 32;
	localparam int GROUP_W = GRAY_W * GROUP;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_RAW_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RAW_HEIGHT = 2'd1;
	localparam logic [CNT_W-1:0]     SIZE_RESET     = 12'd128;

	// exponential luminance levels
	localparam logic [7:0] LUM [64] = '{
		8'd254, 8'd235, 8'd217, 8'd201, 8'd186, 8'd172, 8'd159, 8'd147,
		8'd136, 8'd125, 8'd116, 8'd107, 8'd99,  8'd91,  8'd84,  8'd78,
		8'd72,  8'd66,  8'd61,  8'd57,  8'd52,  8'd48,  8'd44,  8'd41,
		8'd38,  8'd35,  8'd32,  8'd30,  8'd27,  8'd25,  8'd23,  8'd21,
		8'd20,  8'd18,  8'd16,  8'd15,  8'd14,  8'd13,  8'd12,  8'd11,
		8'd10,  8'd9,   8'd8,   8'd7,   8'd7,   8'd6,   8'd6,   8'd5,
		8'd5,   8'd4,   8'd4,   8'd3,   8'd3,   8'd3,   8'd2,   8'd2,
		8'd2,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1
	};

	// 8x8 ordered dither index grid
	localparam logic [5:0] BAYER [64] = '{
		6'd0,  6'd32, 6'd8,  6'd40, 6'd2,  6'd34, 6'd10, 6'd42,
		6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26,
		6'd12, 6'd44, 6'd4,  6'd36, 6'd14, 6'd46, 6'd6,  6'd38,
		6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22,
		6'd3,  6'd35, 6'd11, 6'd43, 6'd1,  6'd33, 6'd9,  6'd41,
		6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25,
		6'd15, 6'd47, 6'd7,  6'd39, 6'd13, 6'd45, 6'd5,  6'd37,
		6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21
	};

	// threshold for one output pixel position in the dither cell
	function automatic logic [7:0] thresh(input logic [2:0] oy, input logic [2:0] ox);
		logic [5:0] idx;
		idx = BAYER[{oy, ox}];
		return LUM[idx];
	endfunction

	typedef enum logic [1:0] {
		ST_IN,
		ST_RD,
		ST_LD
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic accept;
		logic clear;
		logic rd;
		logic step;
		logic load;
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic row_end;
		logic last;
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/gthm_ram.sv =====
// generic single write port, registered read ram
`default_nettype none

module gthm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read, holds while not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/gthm_datapath.sv =====
// counters, line buffer, dither compare and output register
`default_nettype none

module gthm_datapath (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire gthm_pkg::dp_cmd_t                 cmd,
	output gthm_pkg::dp_status_t                   status,
	input  wire logic                              cfg_wr_en,
	input  wire logic [gthm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [gthm_pkg::CNT_W-1:0]        cfg_data,
	input  wire logic [gthm_pkg::GRAY_W-1:0]       gray,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic      [gthm_pkg::BITS_W-1:0]       bits,
	output logic                                   row_done
);

	logic [gthm_pkg::CNT_W-1:0]   raw_width_q;
	logic [gthm_pkg::CNT_W-1:0]   raw_height_q;
	logic [gthm_pkg::CNT_W-1:0]   col_q;
	logic [gthm_pkg::CNT_W-1:0]   row_q;
	logic [gthm_pkg::CNT_W-1:0]   kw_raw;
	logic [gthm_pkg::CNT_W-1:0]   kw;
	logic [gthm_pkg::CNT_W-1:0]   kh;
	logic                         keep;
	logic                         col_wrap;
	logic                         row_wrap;
	logic [gthm_pkg::GROUP_W-1:0] gather_q;
	logic                         ram_wr;
	logic [gthm_pkg::GROUP_W-1:0] ram_wdata;
	logic                         ram_rd;
	logic [gthm_pkg::WADDR_W-1:0] ram_raddr;
	logic [gthm_pkg::GROUP_W-1:0] ram_rdata;
	logic                         odd_q;
	logic [gthm_pkg::WADDR_W-1:0] w_q;
	logic [1:0]                   my_q;
	logic [gthm_pkg::WADDR_W-1:0] w_last;
	logic [gthm_pkg::WADDR_W-1:0] w_nxt;
	logic [1:0]                   my_nxt;
	logic                         last;
	logic [gthm_pkg::BITS_W-1:0]  word;
	logic                         out_free;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_width_q  <= gthm_pkg::SIZE_RESET;
			raw_height_q <= gthm_pkg::SIZE_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				gthm_pkg::REG_RAW_WIDTH:  raw_width_q  <= cfg_data;
				gthm_pkg::REG_RAW_HEIGHT: raw_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// kept sizes and pixel classification
	assign kw_raw   = {raw_width_q[gthm_pkg::CNT_W-1:5], 5'd0};
	assign kw       = (kw_raw > gthm_pkg::CNT_W'(gthm_pkg::LINE_KEEP)) ?
		gthm_pkg::CNT_W'(gthm_pkg::LINE_KEEP) : kw_raw;
	assign kh       = {raw_height_q[gthm_pkg::CNT_W-1:5], 5'd0};
	assign keep     = (row_q < kh) && (col_q < kw);
	assign col_wrap = ({1'b0, col_q} + 13'd1) >= {1'b0, raw_width_q};
	assign row_wrap = ({1'b0, row_q} + 13'd1) >= {1'b0, raw_height_q};

	// raw position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.accept) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// gather eight pixels into one buffer word
	always_ff @(posedge clk) begin
		if (cmd.accept && keep) begin
			gather_q[col_q[2:0]*gthm_pkg::GRAY_W +: gthm_pkg::GRAY_W] <= gray;
		end
	end

	assign ram_wr    = cmd.accept && keep && (col_q[2:0] == 3'd7);
	assign ram_wdata = {gray, gather_q[gthm_pkg::GROUP_W-gthm_pkg::GRAY_W-1:0]};

	// emission word and magnified row indexes
	assign w_last = gthm_pkg::WADDR_W'(kw[gthm_pkg::CNT_W-1:3] - 1'b1);
	assign last   = (my_q == 2'd3) && (w_q == w_last);
	assign w_nxt  = (w_q == w_last) ? '0 : w_q + 1'b1;
	assign my_nxt = (w_q == w_last) ? my_q + 2'd1 : my_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q   <= '0;
			my_q  <= '0;
			odd_q <= 1'b0;
		end else if (cmd.clear) begin
			w_q   <= '0;
			my_q  <= '0;
			odd_q <= row_q[0];
		end else if (cmd.step) begin
			w_q  <= w_nxt;
			my_q <= my_nxt;
		end
	end

	assign ram_rd    = cmd.rd || cmd.step;
	assign ram_raddr = cmd.step ? w_nxt : w_q;

	gthm_ram #(
		.WIDTH (gthm_pkg::GROUP_W),
		.DEPTH (gthm_pkg::WORDS)
	) u_line (
		.clk     (clk),
		.wr_en   (ram_wr),
		.wr_addr (col_q[gthm_pkg::WADDR_W+2:3]),
		.wr_data (ram_wdata),
		.rd_en   (ram_rd),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	// dither compare, four output pixels per source pixel
	always_comb begin
		for (int p = 0; p < gthm_pkg::GROUP; p++) begin
			for (int mx = 0; mx < 4; mx++) begin
				word[p*4+mx] = ram_rdata[p*gthm_pkg::GRAY_W +: gthm_pkg::GRAY_W] <
					gthm_pkg::thresh({odd_q, my_q}, {p[0], mx[1:0]});
			end
		end
	end

	// output register
	assign out_free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bits     <= word;
			row_done <= last;
		end
	end

	assign status.row_end  = keep && (({1'b0, col_q} + 13'd1) == {1'b0, kw});
	assign status.last     = last;
	assign status.out_free = out_free;

endmodule

`default_nettype wire

// ===== rtl/gthm_ctrl.sv =====
// controller: pixel intake, then row replay one word per cycle while the output is not stalled
`default_nettype none

module gthm_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire gthm_pkg::dp_status_t status,
	output gthm_pkg::dp_cmd_t         cmd
);

	gthm_pkg::state_t state_q;
	gthm_pkg::state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gthm_pkg::ST_IN;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and commands
	always_comb begin
		state_nxt  = state_q;
		cmd        = '0;
		in_stall   = 1'b1;
		case (state_q)
			gthm_pkg::ST_IN: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
				if (in_valid && status.row_end) begin
					cmd.clear = 1'b1;
					state_nxt = gthm_pkg::ST_RD;
				end
			end
			gthm_pkg::ST_RD: begin
				cmd.rd    = 1'b1;
				state_nxt = gthm_pkg::ST_LD;
			end
			gthm_pkg::ST_LD: begin
				if (status.out_free) begin
					cmd.load = 1'b1;
					if (status.last) begin
						state_nxt = gthm_pkg::ST_IN;
					end else begin
						cmd.step = 1'b1;
					end
				end
			end
			default: begin
				state_nxt = gthm_pkg::ST_IN;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/gray_to_halftone_magnify.sv =====
// top level: gray pixel stream to 4x magnified ordered-dither bit words
//
// channel   direction  handshake            payload
// in        input      in_valid / in_stall   gray[7:0]
// out       output     out_valid / out_stall bits[31:0], row_done
// cfg       input      cfg_wr_en             cfg_index[1:0], cfg_data[11:0]
//
// one pixel per cycle is taken while a row streams in
// after the last kept pixel of a kept row, intake stalls for the replay: one line
// buffer read, then kept_width/2 words, one per cycle from its single read port
// an output stall holds the replay; reset leaves sizes at 128 and counters at 0
`default_nettype none

module gray_to_halftone_magnify (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [gthm_pkg::GRAY_W-1:0]       gray,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic      [gthm_pkg::BITS_W-1:0]       bits,
	output logic                                   row_done,
	input  wire logic                              cfg_wr_en,
	input  wire logic [gthm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [gthm_pkg::CNT_W-1:0]        cfg_data
);

	gthm_pkg::dp_cmd_t    cmd;
	gthm_pkg::dp_status_t status;

	gthm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	gthm_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.gray      (gray),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.bits      (bits),
		.row_done  (row_done)
	);

	// a request that completes a kept row stops intake for the replay
	a_row_end_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && status.row_end |=> in_stall)
		else $error("intake not stalled after row end");

	// a word is only loaded when the output register can take it
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> status.out_free)
		else $error("output word overwritten");

	// the last word of a replay returns control to intake and flags the row
	a_last_resumes: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && status.last |=> !in_stall && out_valid && row_done)
		else $error("replay end not handled");

	// no intake while a replay word is being loaded
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !cmd.accept && in_stall)
		else $error("intake during replay");

endmodule

`default_nettype wire
